[design/hcg_pkg.sv]
// Shared types and constants for the height colour gradient block.
`default_nettype none

package hcg_pkg;

  // Quotient bits of each colour channel
  localparam int QUOT_BITS = 8;

  localparam logic [7:0]  CHAN_MAX   = 8'hFF;
  localparam logic [7:0]  ALPHA_BYTE = 8'hFF;
  localparam logic [31:0] WHITE_WORD = 32'hFFFF_FFFF;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HEIGHT_LOW  = 2'd0,
    REG_HEIGHT_HIGH = 2'd1
  } cfg_reg_t;

  // Sideband that travels alongside each sample
  typedef struct packed {
    logic valid;
    logic white;   // empty or inverted scale
    logic upper;   // green-to-red half
  } hcg_ctrl_t;

endpackage

`default_nettype wire

[design/height_color_gradient.sv]
// Height to colour mapper: blue-green-red scale between two configured heights.
// Pipeline: out_valid strobes for each start transfer once it has passed 3 front stages,
//   8 divider stages and 1 output register. Throughput: one sample per cycle.
// Latency is set mostly by the 8-stage restoring divider, one quotient bit per stage.
// busy never rises and the receiver cannot stall, so the pipeline always advances.
// Synchronous active-low reset clears the valid bits and both height registers.
`default_nettype none

module height_color_gradient #(
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // sample channel
  input  wire logic                                      start,
  output logic                                           busy,
  input  wire logic signed [HEIGHT_BITS-1:0]             in_height,
  // result channel
  output logic                                           out_valid,
  output logic [31:0]                                    out_color_word,
  // configuration channel
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [hcg_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire logic [HEIGHT_BITS-1:0]                    cfg_data
);

  localparam int HB = HEIGHT_BITS;
  localparam int QB = hcg_pkg::QUOT_BITS;
  localparam int NW = HB + QB;

  // Fully pipelined, never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [HB-1:0] height_low_r;
  logic signed [HB-1:0] height_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_low_r  <= '0;
      height_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hcg_pkg::REG_HEIGHT_LOW:  height_low_r  <= $signed(cfg_data);
        hcg_pkg::REG_HEIGHT_HIGH: height_high_r <= $signed(cfg_data);
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: span r = high - low and offset d = z - low, one bit wider
  // ---------------------------------------------------------------------------
  logic                 a_valid_r;
  logic signed [HB:0]   a_span_r;
  logic signed [HB:0]   a_off_r;
  logic signed [HB:0]   a_span_nxt;
  logic signed [HB:0]   a_off_nxt;

  assign a_span_nxt = (HB+1)'(height_high_r) - (HB+1)'(height_low_r);
  assign a_off_nxt  = (HB+1)'(in_height)     - (HB+1)'(height_low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_span_r <= a_span_nxt;
    a_off_r  <= a_off_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage B: white detect and clamp of d to 0..r
  // ---------------------------------------------------------------------------
  logic          b_valid_r;
  logic          b_white_r;
  logic [HB-1:0] b_span_r;
  logic [HB-1:0] b_off_r;
  logic          b_white_nxt;
  logic [HB-1:0] b_off_nxt;

  assign b_white_nxt = (a_span_r <= 0);

  always_comb begin
    if (a_off_r < 0) begin
      b_off_nxt = '0;
    end else if (a_off_r > a_span_r) begin
      b_off_nxt = a_span_r[HB-1:0];
    end else begin
      b_off_nxt = a_off_r[HB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_white_r <= b_white_nxt;
    b_span_r  <= a_span_r[HB-1:0];  // positive span fits HB bits
    b_off_r   <= b_off_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage C: pick the half and form the dividend.
  //   lower half (2d < r): N = 510 d  -> green = q, blue  = 255 - ceil(N/r)
  //   upper half:          N = 255 (2d - r) -> red = q, green = 255 - ceil(N/r)
  // The second channel follows since 510(r-d) = 255r - 255(2d-r).
  // N < 256 r in both halves, so the quotient fits eight bits.
  // ---------------------------------------------------------------------------
  logic [HB+1:0] c_diff;
  logic          c_upper;
  logic [HB-1:0] c_excess;
  logic [NW-1:0] c_num_hi;
  logic [NW:0]   c_num_lo;
  logic [NW-1:0] c_num;

  assign c_diff   = {1'b0, b_off_r, 1'b0} - (HB+2)'(b_span_r);
  assign c_upper  = !c_diff[HB+1];
  assign c_excess = c_diff[HB-1:0];
  assign c_num_hi = (NW'(c_excess) << 8) - NW'(c_excess);
  assign c_num_lo = ((NW+1)'(b_off_r) << 9) - ((NW+1)'(b_off_r) << 1);
  assign c_num    = c_upper ? c_num_hi : c_num_lo[NW-1:0];

  hcg_pkg::hcg_ctrl_t c_ctl_r;
  hcg_pkg::hcg_ctrl_t c_ctl_nxt;
  logic [NW-1:0]      c_num_r;
  logic [HB-1:0]      c_den_r;

  always_comb begin
    c_ctl_nxt.valid = b_valid_r;
    c_ctl_nxt.white = b_white_r;
    c_ctl_nxt.upper = c_upper;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else begin
      c_ctl_r <= c_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_num_r <= c_num;
    c_den_r <= b_span_r;
  end

  // ---------------------------------------------------------------------------
  // Divider: eight stages; a zero span on the white path is harmless
  // ---------------------------------------------------------------------------
  hcg_pkg::hcg_ctrl_t dv_ctl;
  logic [QB-1:0]      dv_quot;
  logic               dv_rem_nz;

  hcg_divider #(
    .DEN_BITS (HB)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (c_ctl_r),
    .in_num     (c_num_r),
    .in_den     (c_den_r),
    .out_ctl    (dv_ctl),
    .out_quot   (dv_quot),
    .out_rem_nz (dv_rem_nz)
  );

  // ---------------------------------------------------------------------------
  // Output: assemble ARGB and byte-reverse -> {blue, green, red, alpha}
  // ---------------------------------------------------------------------------
  logic [7:0]  o_comp;
  logic [7:0]  o_red;
  logic [7:0]  o_green;
  logic [7:0]  o_blue;
  logic [31:0] o_word_nxt;
  logic        out_valid_r;
  logic [31:0] out_color_word_r;

  // 255 - ceil(N/r)
  assign o_comp = hcg_pkg::CHAN_MAX - dv_quot - 8'(dv_rem_nz);

  always_comb begin
    if (dv_ctl.upper) begin
      o_red   = dv_quot;
      o_green = o_comp;
      o_blue  = 8'h00;
    end else begin
      o_red   = 8'h00;
      o_green = dv_quot;
      o_blue  = o_comp;
    end
    if (dv_ctl.white) begin
      o_word_nxt = hcg_pkg::WHITE_WORD;
    end else begin
      o_word_nxt = {o_blue, o_green, o_red, hcg_pkg::ALPHA_BYTE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_color_word_r <= o_word_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_color_word = out_color_word_r;

endmodule

`default_nettype wire

[design/hcg_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module hcg_divider #(
  parameter int DEN_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire hcg_pkg::hcg_ctrl_t                     in_ctl,
  input  wire logic [DEN_BITS+hcg_pkg::QUOT_BITS-1:0] in_num,
  input  wire logic [DEN_BITS-1:0]                    in_den,
  output hcg_pkg::hcg_ctrl_t                          out_ctl,
  output logic [hcg_pkg::QUOT_BITS-1:0]               out_quot,
  output logic                                        out_rem_nz
);

  localparam int QB = hcg_pkg::QUOT_BITS;
  localparam int NW = DEN_BITS + QB;

  hcg_pkg::hcg_ctrl_t ctl_r  [QB];
  logic [NW-1:0]       rem_r  [QB];
  logic [DEN_BITS-1:0] den_r  [QB];
  logic [QB-1:0]       quot_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SHIFT = QB - 1 - k;

    hcg_pkg::hcg_ctrl_t src_ctl;
    logic [NW-1:0]       src_rem;
    logic [DEN_BITS-1:0] src_den;
    logic [QB-1:0]       src_quot;
    logic [NW-1:0]       shifted;
    logic                ge;
    logic [NW-1:0]       rem_nxt;
    logic [QB-1:0]       quot_nxt;

    if (k == 0) begin : g_first
      assign src_ctl  = in_ctl;
      assign src_rem  = in_num;
      assign src_den  = in_den;
      assign src_quot = '0;
    end else begin : g_next
      assign src_ctl  = ctl_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_quot = quot_r[k-1];
    end

    assign shifted  = NW'(src_den) << SHIFT;
    assign ge       = (src_rem >= shifted);
    assign rem_nxt  = ge ? (src_rem - shifted) : src_rem;
    assign quot_nxt = {src_quot[QB-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= src_den;
      quot_r[k] <= quot_nxt;
    end
  end

  assign out_ctl    = ctl_r[QB-1];
  assign out_quot   = quot_r[QB-1];
  assign out_rem_nz = (rem_r[QB-1] != '0);

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the height colour gradient mapper.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HB = 16;

  // Register indexes with no register behind them; writes there must be dropped
  localparam logic [hcg_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [hcg_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  localparam int HEIGHT_MIN = -32768;
  localparam int HEIGHT_MAX = 32767;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic signed [HB-1:0]               in_height;
  logic                               out_valid;
  logic [31:0]                        out_color_word;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [hcg_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [HB-1:0]                      cfg_data;

  // Predictor copy of the two scale registers
  logic signed [HB-1:0]           scale_low;
  logic signed [HB-1:0]           scale_high;

  logic [31:0]                    pending_colours[$];
  int                             colour_errors;
  bit                             pace_gaps;

  height_color_gradient #(.HEIGHT_BITS(HB)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_height      (in_height),
    .out_valid      (out_valid),
    .out_color_word (out_color_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Colour for one height against the current scale.
  // Lower half: blue fades to green; upper half (midpoint included): green to red.
  // Blue uses a ceiling so that blue + green never exceeds full scale.
  function automatic logic [31:0] expected_colour(logic signed [HB-1:0] z);
    longint     span;
    longint     offs;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    span = longint'(scale_high) - longint'(scale_low);
    if (span <= 0) return hcg_pkg::WHITE_WORD;   // empty or inverted scale
    offs = longint'(z) - longint'(scale_low);
    if (offs < 0) offs = 0;
    if (offs > span) offs = span;
    red = '0;
    green = '0;
    blue = '0;
    if (2 * offs < span) begin
      green = 8'((510 * offs) / span);
      blue  = 8'(255 - (510 * offs + span - 1) / span);
    end else begin
      red   = 8'((255 * (2 * offs - span)) / span);
      green = 8'((510 * (span - offs)) / span);
    end
    // ARGB byte-reversed: blue on top, alpha at the bottom
    return {blue, green, red, hcg_pkg::ALPHA_BYTE};
  endfunction

  // Single monitor: register transfers, sample transfers and result checks all
  // sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == hcg_pkg::REG_HEIGHT_LOW) scale_low = cfg_data;
        else if (cfg_index == hcg_pkg::REG_HEIGHT_HIGH) scale_high = cfg_data;
      end
      if (start && !busy) pending_colours.push_back(expected_colour(in_height));
      if (out_valid) begin
        if (pending_colours.size() == 0) begin
          colour_errors++;
          if (colour_errors <= 10)
            $display("%0t: unexpected colour %08h, nothing pending", $realtime,
                     out_color_word);
        end else begin
          logic [31:0] want;
          want = pending_colours.pop_front();
          if (out_color_word !== want) begin
            colour_errors++;
            if (colour_errors <= 10)
              $display("%0t: color_word mismatch: expected %08h, got %08h",
                       $realtime, want, out_color_word);
          end
        end
      end
    end
  end

  // One sample transfer, preceded by a random pause when pacing is on.
  task automatic send_height(input logic signed [HB-1:0] z);
    int gap;
    gap = pace_gaps ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      in_height <= HB'($urandom);   // noise while idle
    end
    @(negedge clk);
    start     <= 1'b1;
    in_height <= z;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and let every pending colour come back.
  task automatic wait_for_colours();
    @(negedge clk);
    start <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale_reg(input logic [hcg_pkg::CFG_INDEX_BITS-1:0] idx,
                                 input logic [HB-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_scale(input int lo, input int hi);
    wait_for_colours();
    write_scale_reg(hcg_pkg::REG_HEIGHT_LOW, HB'(lo));
    write_scale_reg(hcg_pkg::REG_HEIGHT_HIGH, HB'(hi));
  endtask

  // Both registers reset to zero, so every height must come back white
  task automatic test_reset_scale();
    send_height(HB'(HEIGHT_MIN));
    send_height(HB'(HEIGHT_MAX));
    send_height('0);
  endtask

  task automatic test_directed_scales();
    // Widest scale
    set_scale(HEIGHT_MIN, HEIGHT_MAX);
    send_height(HB'(HEIGHT_MIN));
    send_height(HB'(HEIGHT_MAX));
    send_height('0);
    send_height(HB'(-1));
    // Tiny even scale: exact midpoint lands in the upper half
    set_scale(0, 2);
    send_height(HB'(0));
    send_height(HB'(1));
    send_height(HB'(2));
    send_height(HB'(-5));      // below the scale: pure blue
    send_height(HB'(100));     // above the scale: pure red
    send_height(HB'(HEIGHT_MIN));
    send_height(HB'(HEIGHT_MAX));
    // Unit scale straddling zero
    set_scale(-1, 0);
    send_height(HB'(-1));
    send_height(HB'(0));
    // Inverted and empty scales give white
    set_scale(100, -100);
    send_height(HB'(0));
    send_height(HB'(HEIGHT_MAX));
    set_scale(5, 5);
    send_height(HB'(5));
  endtask

  // Writes to indexes with no register must leave the scale alone
  task automatic test_spare_indexes();
    set_scale(-300, 700);
    write_scale_reg(REG_SPARE_A, 16'h5A5A);
    write_scale_reg(REG_SPARE_B, 16'hA5A5);
    send_height(HB'(-300));
    send_height(HB'(200));
    send_height(HB'(450));
  endtask

  task automatic test_random_scales(input int phases, input int per_phase);
    int lo;
    int hi;
    int tmp;
    int kind;
    for (int p = 0; p < phases; p++) begin
      kind = $urandom_range(0, 9);
      lo = int'($urandom_range(0, 65535)) + HEIGHT_MIN;
      hi = int'($urandom_range(0, 65535)) + HEIGHT_MIN;
      if (kind == 0) begin
        // raw draw, may well be inverted
      end else if (kind <= 3) begin
        // narrow scale stresses the small-divisor end of the divider
        hi = lo + int'($urandom_range(1, 8));
        if (hi > HEIGHT_MAX) begin
          hi = HEIGHT_MAX;
          lo = hi - 3;
        end
      end else if (lo > hi) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      set_scale(lo, hi);
      if (kind >= 8) write_scale_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                                     HB'($urandom));
      // alternate paced and back-to-back stretches
      pace_gaps = p[0];
      for (int i = 0; i < per_phase; i++) begin
        // pause mid-stream until the pipeline has emptied
        if (p == 3 && i == per_phase / 2) wait_for_colours();
        if (hi > lo && $urandom_range(0, 9) < 7)
          send_height(HB'(lo + int'($urandom_range(0, hi - lo))));
        else
          send_height(HB'($urandom));
      end
    end
  endtask

  initial begin
    int settle;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_height     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = hcg_pkg::REG_HEIGHT_LOW;
    cfg_data      = '0;
    scale_low     = '0;
    scale_high    = '0;
    colour_errors = 0;
    pace_gaps     = 1'b1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_scale();
    test_directed_scales();
    test_spare_indexes();
    test_random_scales(12, 60);

    wait_for_colours();
    // Pipeline is 12 deep; watch a little longer for stray strobes
    settle = 0;
    while (settle < 20) begin
      @(posedge clk);
      settle++;
    end
    if (pending_colours.size() != 0) colour_errors++;

    if (colour_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/hcg_pkg.sv
design/hcg_divider.sv
design/height_color_gradient.sv
verif/testbench.sv
